>>> src/skltp_pkg.sv
// ----------------------------------------------------------------------------
// skltp_pkg
// shared types and constants for the string key linear probe table
// ----------------------------------------------------------------------------
`default_nettype none

package skltp_pkg;

  localparam int HASH_W = 32;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

  localparam int TDATA_IN_W  = 40;
  localparam int TDATA_OUT_W = 40;
  localparam int HANDLE_W    = 32;
  localparam int SLOT_OUT_W  = 6;

  typedef enum logic [1:0] {
    KIND_EMPTY = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_TOMB  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_FOUND    = 3'd3,
    ST_MISSING  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_MOD,
    S_SLOT_RD,
    S_SLOT_CHK,
    S_COPY_RD,
    S_COPY_WR,
    S_CMP_RD,
    S_CMP_CHK,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

>>> src/string_key_linear_probe_table_unit.sv
// ----------------------------------------------------------------------------
// string_key_linear_probe_table_unit
// open addressing string key table with linear probing, fnv-1a style hash
// ----------------------------------------------------------------------------
// in channel: one key byte per word, tlast on the final byte, tuser = command
// (0 insert, 1 lookup); the handle is taken from the tlast word.
// non-final bytes are taken one per cycle. the final byte starts a sequence:
// setup, the slot remainder (reciprocal multiply), then per probed slot a
// read and a check, plus a read and a write per key byte copied on insert,
// or a read and a compare per key byte on a lookup candidate, then the
// result register is loaded. an overlong key goes from setup to the result.
// out channel: one word per final byte, tuser = status, held until taken.
// a new key is accepted while a result waits; its own result waits in turn.
// after reset a clearing pass marks every slot empty;
// in_tready stays low during that pass.
// ----------------------------------------------------------------------------
`default_nettype none

module string_key_linear_probe_table_unit #(
  parameter int TABLE_SLOTS   = 64,
  parameter int MAX_KEY_BYTES = 32,
  parameter int HANDLE_BITS   = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // key_byte[7:0], texture_handle[39:8]
  input  wire logic        in_tuser,   // cmd
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // found_handle[31:0], slot_index[37:32]
  output logic [2:0]       out_tuser   // status
);
  import skltp_pkg::*;

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int CW = $clog2(MAX_KEY_BYTES + 1);
  localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int KB_DEPTH = 1 << KW;
  localparam int SB_DEPTH = TABLE_SLOTS << KW;

  state_t state_r, state_nxt;

  logic [SW-1:0]          slot_r, slot_nxt, slot_inc;
  logic [SW-1:0]          probe_r, probe_nxt;
  logic [KW-1:0]          idx_r, idx_nxt;
  logic                   cmd_r, cmd_nxt;
  logic [HANDLE_BITS-1:0] hdl_in_r, hdl_in_nxt;
  status_t                res_status_r, res_status_nxt;
  logic [HANDLE_W-1:0]    res_handle_r, res_handle_nxt;
  logic [SLOT_OUT_W-1:0]  res_slot_r, res_slot_nxt;

  logic                   out_tvalid_r, out_tvalid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [HANDLE_W-1:0]    out_handle_r, out_handle_nxt;
  logic [SLOT_OUT_W-1:0]  out_slot_r, out_slot_nxt;

  logic                   in_acc;
  logic [31:0]            hash;
  logic [CW-1:0]          key_count;
  logic                   too_long;
  logic                   hash_clear;
  logic                   mod_start, mod_done;
  logic [SW-1:0]          mod_rem;

  logic                   kind_we, meta_we, sb_we, kb_we;
  kind_t                  kind_wd;
  logic                   last_probe, last_idx, advance;

  kind_t                  kind_mem [TABLE_SLOTS];
  logic [CW-1:0]          len_mem  [TABLE_SLOTS];
  logic [HANDLE_BITS-1:0] hdl_mem  [TABLE_SLOTS];
  logic [7:0]             kb_mem   [KB_DEPTH];
  logic [7:0]             sb_mem   [SB_DEPTH];

  kind_t                  kind_q;
  logic [CW-1:0]          len_q;
  logic [HANDLE_BITS-1:0] hdl_q;
  logic [7:0]             kb_q, sb_q;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  skltp_hash #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES),
    .CW            (CW)
  ) u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_acc),
    .key_byte  (in_tdata[7:0]),
    .clear     (hash_clear),
    .hash      (hash),
    .key_count (key_count),
    .too_long  (too_long)
  );

  skltp_mod #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .SW          (SW)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .value (hash),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // key buffer
  assign kb_we = in_acc && (key_count < CW'(MAX_KEY_BYTES));

  always_ff @(posedge clk) begin
    if (kb_we) begin
      kb_mem[key_count[KW-1:0]] <= in_tdata[7:0];
    end
    kb_q <= kb_mem[idx_r];
  end

  // slot memories
  always_ff @(posedge clk) begin
    if (kind_we) begin
      kind_mem[slot_r] <= kind_wd;
    end
    kind_q <= kind_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      len_mem[slot_r] <= key_count;
      hdl_mem[slot_r] <= hdl_in_r;
    end
    len_q <= len_mem[slot_r];
    hdl_q <= hdl_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (sb_we) begin
      sb_mem[{slot_r, idx_r}] <= kb_q;
    end
    sb_q <= sb_mem[{slot_r, idx_r}];
  end

  assign slot_inc   = (slot_r == SW'(TABLE_SLOTS - 1)) ? '0 : slot_r + 1'b1;
  assign last_probe = (probe_r == SW'(TABLE_SLOTS - 1));
  assign last_idx   = (CW'(idx_r) == key_count - 1'b1);

  always_comb begin
    state_nxt      = state_r;
    slot_nxt       = slot_r;
    probe_nxt      = probe_r;
    idx_nxt        = idx_r;
    cmd_nxt        = cmd_r;
    hdl_in_nxt     = hdl_in_r;
    res_status_nxt = res_status_r;
    res_handle_nxt = res_handle_r;
    res_slot_nxt   = res_slot_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    out_slot_nxt   = out_slot_r;
    kind_we        = 1'b0;
    kind_wd        = KIND_EMPTY;
    meta_we        = 1'b0;
    sb_we          = 1'b0;
    hash_clear     = 1'b0;
    mod_start      = 1'b0;
    advance        = 1'b0;

    case (state_r)
      S_CLEAR: begin
        kind_we  = 1'b1;
        kind_wd  = KIND_EMPTY;
        slot_nxt = slot_inc;
        if (slot_r == SW'(TABLE_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc && in_tlast) begin
          cmd_nxt    = in_tuser;
          hdl_in_nxt = HANDLE_BITS'(in_tdata[39:8]);
          state_nxt  = S_EVAL;
        end
      end
      S_EVAL: begin
        res_handle_nxt = '0;
        res_slot_nxt   = '0;
        if (too_long) begin
          res_status_nxt = ST_TOO_LONG;
          state_nxt      = S_DONE;
        end else begin
          mod_start = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          slot_nxt  = mod_rem;
          probe_nxt = '0;
          state_nxt = S_SLOT_RD;
        end
      end
      S_SLOT_RD: begin
        state_nxt = S_SLOT_CHK;
      end
      S_SLOT_CHK: begin
        idx_nxt = '0;
        if (!cmd_r) begin
          if (kind_q != KIND_VALUE) begin
            kind_we   = 1'b1;
            kind_wd   = KIND_VALUE;
            meta_we   = 1'b1;
            state_nxt = S_COPY_RD;
          end else begin
            advance = 1'b1;
          end
        end else begin
          if (kind_q == KIND_VALUE && len_q == key_count) begin
            state_nxt = S_CMP_RD;
          end else begin
            advance = 1'b1;
          end
        end
      end
      S_COPY_RD: begin
        state_nxt = S_COPY_WR;
      end
      S_COPY_WR: begin
        sb_we = 1'b1;
        if (last_idx) begin
          res_status_nxt = ST_INSERTED;
          res_slot_nxt   = SLOT_OUT_W'(slot_r);
          state_nxt      = S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_COPY_RD;
        end
      end
      S_CMP_RD: begin
        state_nxt = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (kb_q != sb_q) begin
          advance = 1'b1;
        end else if (last_idx) begin
          res_status_nxt = ST_FOUND;
          res_handle_nxt = HANDLE_W'(hdl_q);
          res_slot_nxt   = SLOT_OUT_W'(slot_r);
          state_nxt      = S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_CMP_RD;
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_status_nxt = res_status_r;
          out_handle_nxt = res_handle_r;
          out_slot_nxt   = res_slot_r;
          hash_clear     = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // move to the next slot in probe order or give up
    if (advance) begin
      if (last_probe) begin
        res_status_nxt = cmd_r ? ST_MISSING : ST_FULL;
        state_nxt      = S_DONE;
      end else begin
        slot_nxt  = slot_inc;
        probe_nxt = probe_r + 1'b1;
        state_nxt = S_SLOT_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      slot_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_r       <= slot_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_r      <= probe_nxt;
    idx_r        <= idx_nxt;
    cmd_r        <= cmd_nxt;
    hdl_in_r     <= hdl_in_nxt;
    res_status_r <= res_status_nxt;
    res_handle_r <= res_handle_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(TDATA_OUT_W - HANDLE_W - SLOT_OUT_W){1'b0}}, out_slot_r, out_handle_r};

  a_word_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_DONE))
    else $error("result word raised outside the done state");

  a_last_starts_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> state_r == S_EVAL)
    else $error("final byte did not start the probe sequence");

  a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> state_r == S_MOD)
    else $error("remainder finished outside its wait state");

  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_status_r != ST_FOUND |-> out_handle_r == '0)
    else $error("handle nonzero on a result other than found");

  a_held_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE && state_r != S_DONE && state_r != S_CLEAR &&
      state_r != S_EVAL |-> !in_tready && $stable(key_count))
    else $error("key state changed while probing");

endmodule

`default_nettype wire

>>> src/skltp_hash.sv
// ----------------------------------------------------------------------------
// skltp_hash
// running fnv-1a style hash, key byte count and overlong flag
// ----------------------------------------------------------------------------
`default_nettype none

module skltp_hash #(
  parameter int MAX_KEY_BYTES = 32,
  parameter int CW            = $clog2(MAX_KEY_BYTES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic [7:0]    key_byte,
  input  wire logic          clear,
  output logic [31:0]        hash,
  output logic [CW-1:0]      key_count,
  output logic               too_long
);
  import skltp_pkg::*;

  logic [HASH_W-1:0] hash_r, hash_nxt, mix;
  logic [CW-1:0]     count_r, count_nxt;
  logic              too_long_r, too_long_nxt;
  logic              room;

  assign mix  = hash_r ^ {{(HASH_W-8){key_byte[7]}}, key_byte};
  assign room = count_r < CW'(MAX_KEY_BYTES);

  always_comb begin
    hash_nxt     = hash_r;
    count_nxt    = count_r;
    too_long_nxt = too_long_r;
    if (clear) begin
      hash_nxt     = '0;
      count_nxt    = '0;
      too_long_nxt = 1'b0;
    end else if (step) begin
      hash_nxt = mix * FNV_PRIME;
      if (room) begin
        count_nxt = count_r + 1'b1;
      end else begin
        too_long_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r     <= '0;
      count_r    <= '0;
      too_long_r <= 1'b0;
    end else begin
      hash_r     <= hash_nxt;
      count_r    <= count_nxt;
      too_long_r <= too_long_nxt;
    end
  end

  assign hash      = hash_r;
  assign key_count = count_r;
  assign too_long  = too_long_r;

endmodule

`default_nettype wire

>>> src/skltp_mod.sv
// ----------------------------------------------------------------------------
// skltp_mod
// remainder of the hash by the slot count through a reciprocal multiply
// ----------------------------------------------------------------------------
`default_nettype none

module skltp_mod #(
  parameter int TABLE_SLOTS = 64,
  parameter int SW          = $clog2(TABLE_SLOTS)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [31:0]   value,
  output logic               done,
  output logic [SW-1:0]      rem
);
  import skltp_pkg::*;

  localparam int PW = 2 * HASH_W + 1;
  // ceil(2^(HASH_W+SW) / TABLE_SLOTS), fits in HASH_W+1 bits
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << (HASH_W + SW)) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
  localparam logic [HASH_W:0] RECIP    = RECIP_WIDE[HASH_W:0];
  localparam logic [SW-1:0]   SLOTS_LO = SW'(TABLE_SLOTS);

  logic [HASH_W-1:0] val_r, val_nxt;
  logic [SW-1:0]     quo_r, quo_nxt;
  logic [SW-1:0]     rem_r, rem_nxt;
  logic              mul_r, mul_nxt;
  logic              fix_r, fix_nxt;
  logic              done_r, done_nxt;
  logic [PW-1:0]     prod;

  assign prod = PW'(val_r) * PW'(RECIP);

  always_comb begin
    val_nxt  = val_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    mul_nxt  = 1'b0;
    fix_nxt  = 1'b0;
    done_nxt = 1'b0;
    if (start) begin
      val_nxt = value;
      mul_nxt = 1'b1;
    end
    // low bits of the quotient are all the remainder needs
    if (mul_r) begin
      quo_nxt = SW'(prod >> (HASH_W + SW));
      fix_nxt = 1'b1;
    end
    if (fix_r) begin
      rem_nxt  = val_r[SW-1:0] - quo_r * SLOTS_LO;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= mul_nxt;
      fix_r  <= fix_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

>>> dv/skltp_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// skltp_tb_pkg
// command codes shared by the table testbench and its checker
// ----------------------------------------------------------------------------
package skltp_tb_pkg;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } key_cmd_t;

endpackage

>>> dv/string_key_linear_probe_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// string_key_linear_probe_table_checker
// watches both streams of the key table, keeps its own copy of the hash,
// key buffer and slot contents, and checks every result word in order
// against the status, handle and slot it expects
// ----------------------------------------------------------------------------
module string_key_linear_probe_table_checker #(
  parameter int TABLE_SLOTS   = 64,
  parameter int MAX_KEY_BYTES = 32,
  parameter int HANDLE_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // key_byte[7:0], texture_handle[39:8]
  input  logic        in_tuser,   // cmd
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // found_handle[31:0], slot_index[37:32]
  input  logic [2:0]  out_tuser,  // status
  output int          mismatch_count,
  output int          results_owed
);
  import skltp_pkg::*;
  import skltp_tb_pkg::*;

  localparam logic [HANDLE_W-1:0] HANDLE_MASK =
    (HANDLE_BITS >= HANDLE_W) ? '1 : ((HANDLE_W'(1) << HANDLE_BITS) - 1'b1);

  typedef struct packed {
    status_t                 status;
    logic [HANDLE_W-1:0]     handle;
    logic [SLOT_OUT_W-1:0]   slot;
  } table_answer_t;

  table_answer_t owed_answers[$];

  logic [HASH_W-1:0]   key_hash;
  int                  key_len;
  bit                  key_overlong;
  logic [7:0]          key_bytes   [MAX_KEY_BYTES];
  kind_t               slot_kind   [TABLE_SLOTS];
  int                  slot_len    [TABLE_SLOTS];
  logic [7:0]          slot_bytes  [TABLE_SLOTS][MAX_KEY_BYTES];
  logic [HANDLE_W-1:0] slot_handle [TABLE_SLOTS];
  int                  fails;

  function automatic bit slot_holds_key(input int s);
    int j;
    if (slot_kind[s] != KIND_VALUE || slot_len[s] != key_len) return 1'b0;
    for (j = 0; j < key_len; j++) begin
      if (slot_bytes[s][j] != key_bytes[j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // folds one key byte in; on the final byte runs the command
  function automatic bit absorb_key_byte(input key_cmd_t cmd, input logic [7:0] b,
                                         input bit last, input logic [31:0] handle,
                                         output table_answer_t ans);
    logic [HASH_W-1:0] ext;
    int                start;
    int                s;
    int                i;
    int                j;
    bit                done;
    ext      = {{24{b[7]}}, b};
    key_hash = (key_hash ^ ext) * FNV_PRIME;
    if (key_len < MAX_KEY_BYTES) begin
      key_bytes[key_len] = b;
      key_len++;
    end else begin
      key_overlong = 1'b1;
    end
    if (!last) return 1'b0;

    ans.status = ST_MISSING;
    ans.handle = '0;
    ans.slot   = '0;
    start      = int'(key_hash % TABLE_SLOTS);
    done       = 1'b0;
    if (key_overlong) begin
      ans.status = ST_TOO_LONG;
    end else if (cmd == CMD_INSERT) begin
      ans.status = ST_FULL;
      for (i = 0; i < TABLE_SLOTS && !done; i++) begin
        s = (start + i) % TABLE_SLOTS;
        if (slot_kind[s] == KIND_EMPTY || slot_kind[s] == KIND_TOMB) begin
          slot_kind[s]   = KIND_VALUE;
          slot_len[s]    = key_len;
          for (j = 0; j < key_len; j++) slot_bytes[s][j] = key_bytes[j];
          slot_handle[s] = handle & HANDLE_MASK;
          ans.status     = ST_INSERTED;
          ans.slot       = SLOT_OUT_W'(s);
          done           = 1'b1;
        end
      end
    end else begin
      for (i = 0; i < TABLE_SLOTS && !done; i++) begin
        s = (start + i) % TABLE_SLOTS;
        if (slot_holds_key(s)) begin
          ans.status = ST_FOUND;
          ans.handle = slot_handle[s];
          ans.slot   = SLOT_OUT_W'(s);
          done       = 1'b1;
        end
      end
    end
    key_hash     = '0;
    key_len      = 0;
    key_overlong = 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    table_answer_t want;
    table_answer_t fresh;
    int            s;
    if (!rst_n) begin
      key_hash     = '0;
      key_len      = 0;
      key_overlong = 1'b0;
      for (s = 0; s < TABLE_SLOTS; s++) slot_kind[s] = KIND_EMPTY;
      owed_answers.delete();
    end else begin
      // results first, so a stray word is never matched to this edge's key
      if (out_tvalid && out_tready) begin
        if (owed_answers.size() == 0) begin
          fails++;
          $display("%0t unexpected result word: status %0d handle %h slot %0d",
                   $time, out_tuser, out_tdata[31:0], out_tdata[37:32]);
        end else begin
          want = owed_answers.pop_front();
          if (out_tuser !== want.status || out_tdata[31:0] !== want.handle ||
              out_tdata[37:32] !== want.slot) begin
            fails++;
            $display("%0t mismatch: expected status %0d handle %h slot %0d, got status %0d handle %h slot %0d",
                     $time, want.status, want.handle, want.slot,
                     out_tuser, out_tdata[31:0], out_tdata[37:32]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (absorb_key_byte(key_cmd_t'(in_tuser), in_tdata[7:0], in_tlast,
                            in_tdata[39:8], fresh))
          owed_answers.push_back(fresh);
      end
    end
    mismatch_count <= fails;
    results_owed   <= owed_answers.size();
  end

endmodule

>>> dv/string_key_linear_probe_table_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// string_key_linear_probe_table_unit_tb
// drives keys into the table a byte per word: directed cases first (extreme
// bytes and handles, zero and sign bytes, duplicates, longest and overlong
// keys), then random inserts and lookups over a key pool, then a fill that
// overflows the table; bursty sender, stalling receiver, checker alongside
// ----------------------------------------------------------------------------
module string_key_linear_probe_table_unit_tb;
  import skltp_pkg::*;
  import skltp_tb_pkg::*;

  localparam int     TABLE_SLOTS   = 64;
  localparam int     MAX_KEY_BYTES = 32;
  localparam int     HANDLE_BITS   = 32;
  localparam int     WORD_TARGET   = 380;
  localparam int     POOL_KEYS     = 20;
  localparam int     TX_KEY_MAX    = MAX_KEY_BYTES + 4;
  localparam int     LONG_HOLD     = 600;
  localparam int     DRAIN_CYCLES  = 4500;
  localparam longint CYCLE_LIMIT   = 5_000_000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // key_byte[7:0], texture_handle[39:8]
  logic        in_tuser   = 1'b0; // cmd
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // found_handle[31:0], slot_index[37:32]
  logic [2:0]  out_tuser;         // status

  int          mismatch_count;
  int          results_owed;
  longint      cycle_count   = 0;
  int          words_sent    = 0;
  int          burst_left    = 0;
  bit          long_hold_req = 1'b0;

  logic [7:0]  tx_key   [TX_KEY_MAX];
  logic [7:0]  pool_key [POOL_KEYS][MAX_KEY_BYTES];
  int          pool_len [POOL_KEYS];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  string_key_linear_probe_table_unit #(
    .TABLE_SLOTS  (TABLE_SLOTS),
    .MAX_KEY_BYTES(MAX_KEY_BYTES),
    .HANDLE_BITS  (HANDLE_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  string_key_linear_probe_table_checker #(
    .TABLE_SLOTS  (TABLE_SLOTS),
    .MAX_KEY_BYTES(MAX_KEY_BYTES),
    .HANDLE_BITS  (HANDLE_BITS)
  ) table_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: changing stall patterns plus one long hold-off
  initial begin : result_sink
    int hold_left;
    int pattern_left;
    int pattern_kind;
    bit long_hold_done;
    hold_left      = 0;
    pattern_left   = 0;
    pattern_kind   = 0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !long_hold_done) begin
        hold_left      = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (pattern_left == 0) begin
        pattern_kind = $urandom_range(0, 2);
        pattern_left = $urandom_range(10, 150);
      end
      pattern_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else begin
        case (pattern_kind)
          0:       out_tready = 1'b1;
          1:       out_tready = 1'($urandom_range(0, 1));
          default: out_tready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_word(input key_cmd_t cmd, input logic [7:0] b, input bit last,
                           input logic [31:0] handle);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {handle, b};
    in_tuser  = cmd;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    words_sent++;
  endtask

  // command and handle only count on the final word, so the others get noise
  task automatic send_key(input key_cmd_t cmd, input int len, input logic [31:0] handle);
    int i;
    for (i = 0; i < len - 1; i++)
      send_word(key_cmd_t'($urandom_range(0, 1)), tx_key[i], 1'b0, $urandom);
    send_word(cmd, tx_key[len - 1], 1'b1, handle);
  endtask

  function automatic void fill_random(input int len);
    int i;
    for (i = 0; i < len; i++) tx_key[i] = 8'($urandom_range(0, 255));
  endfunction

  function automatic int load_pool(input int k);
    int i;
    for (i = 0; i < pool_len[k]; i++) tx_key[i] = pool_key[k][i];
    return pool_len[k];
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int       k;
    int       i;
    int       n;
    int       op;
    key_cmd_t cmd;

    for (k = 0; k < POOL_KEYS; k++) begin
      pool_len[k] = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12)
                                                : $urandom_range(1, 4);
      for (i = 0; i < MAX_KEY_BYTES; i++) pool_key[k][i] = 8'($urandom_range(0, 255));
    end

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed
    tx_key[0] = 8'h41;
    send_key(CMD_INSERT, 1, 32'h0000_0000);
    send_key(CMD_LOOKUP, 1, $urandom);
    tx_key[0] = 8'h00;
    send_key(CMD_INSERT, 1, 32'hFFFF_FFFF);
    send_key(CMD_LOOKUP, 1, 32'h0000_0000);
    tx_key[0] = 8'hFF;
    tx_key[1] = 8'h80;
    send_key(CMD_INSERT, 2, $urandom);
    send_key(CMD_LOOKUP, 2, 32'h0000_0000);
    tx_key[0] = 8'h80;
    tx_key[1] = 8'hFF;
    send_key(CMD_LOOKUP, 2, 32'hFFFF_FFFF);
    tx_key[0] = 8'h41;
    send_key(CMD_INSERT, 1, 32'h1234_5678);
    send_key(CMD_LOOKUP, 1, 32'h0000_0000);
    fill_random(MAX_KEY_BYTES);
    send_key(CMD_INSERT, MAX_KEY_BYTES, $urandom);
    send_key(CMD_LOOKUP, MAX_KEY_BYTES, $urandom);
    tx_key[MAX_KEY_BYTES - 1] ^= 8'h01;
    send_key(CMD_LOOKUP, MAX_KEY_BYTES, $urandom);
    fill_random(MAX_KEY_BYTES + 1);
    send_key(CMD_INSERT, MAX_KEY_BYTES + 1, $urandom);
    tx_key[0] = 8'h41;
    send_key(CMD_LOOKUP, 1, $urandom);
    wait_drained();

    // random inserts and lookups over the pool, with some noise
    while (words_sent < WORD_TARGET) begin
      if (words_sent >= 250) long_hold_req = 1'b1;
      op = $urandom_range(0, 99);
      if (op < 35) begin
        n = load_pool($urandom_range(0, POOL_KEYS - 1));
        send_key(CMD_INSERT, n, $urandom);
      end else if (op < 80) begin
        n = load_pool($urandom_range(0, POOL_KEYS - 1));
        send_key(CMD_LOOKUP, n, $urandom);
      end else if (op < 98) begin
        n   = $urandom_range(1, 6);
        cmd = (op < 92) ? CMD_LOOKUP : CMD_INSERT;
        fill_random(n);
        send_key(cmd, n, $urandom);
      end else begin
        n = $urandom_range(MAX_KEY_BYTES + 1, TX_KEY_MAX);
        fill_random(n);
        send_key(key_cmd_t'($urandom_range(0, 1)), n, $urandom);
      end
    end
    wait_drained();

    // overflow the table, then search it when full
    for (k = 0; k < TABLE_SLOTS + 6; k++) begin
      n = $urandom_range(1, 2);
      fill_random(n);
      send_key(CMD_INSERT, n, $urandom);
    end
    for (k = 0; k < 4; k++) begin
      n = load_pool($urandom_range(0, POOL_KEYS - 1));
      send_key(CMD_LOOKUP, n, $urandom);
    end
    fill_random(5);
    send_key(CMD_LOOKUP, 5, $urandom);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
